### src/bmpi_pkg.sv
`timescale 1ns / 1ps

package bmpi_pkg;

    // operation codes
    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_MOTION = 3'd2;
    localparam logic [2:0] OP_BUTTON = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    // port addresses
    localparam logic [1:0] SEL_PORT_A  = 2'd0;
    localparam logic [1:0] SEL_PORT_B  = 2'd1;
    localparam logic [1:0] SEL_PORT_C  = 2'd2;
    localparam logic [1:0] SEL_CONTROL = 2'd3;

    localparam int DEF_COUNT_LIMIT = 2048;
    localparam int DELTA_W         = 13;

    localparam logic [7:0] PORT_C_RESET   = 8'hf0;
    localparam logic [7:0] MODE_RESET     = 8'h93;
    localparam logic [7:0] PORT_A_SIG     = 8'h40;
    localparam logic [7:0] PORT_C_MASK    = 8'h1f;
    localparam logic [3:0] PORT_C_STRAP   = 4'h8;
    localparam logic [7:0] CONTROL_READ   = 8'hff;
    localparam logic [7:0] PORT_B_STRAP   = 8'h40;
    localparam int         SNAP_MAX       = 127;

endpackage

### src/bus_mouse_ppi_interface.sv
`timescale 1ns / 1ps

// Bus mouse behind a parallel peripheral interface. Every transaction on the
// input channel (bus read, bus write, motion, button or interval tick) gives
// exactly one result transaction carrying read_data and irq_pulse. The block
// has an input register and a result register with the update logic between
// them, so it takes one transaction per clock while out_stall is low;
// while out_stall holds a finished result, the input register can
// still take one more transaction and then raises in_stall until the result
// is taken. X and Y counters saturate at
// plus or minus COUNT_LIMIT; a rising edge of port C bit 7 latches both
// counters clamped to signed 8 bits and clears them.
module bus_mouse_ppi_interface #(
    parameter int COUNT_LIMIT = bmpi_pkg::DEF_COUNT_LIMIT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          opcode,
    input  logic [1:0]                          port_select,
    input  logic [7:0]                          write_data,
    input  logic                                axis_is_y,
    input  logic signed [bmpi_pkg::DELTA_W-1:0] motion_delta,
    input  logic                                button_is_right,
    input  logic                                button_down,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          read_data,
    output logic                                irq_pulse
);
    import bmpi_pkg::*;

    localparam int CNT_W = $clog2(COUNT_LIMIT + 1) + 1;
    localparam int SUM_W = ((CNT_W > DELTA_W) ? CNT_W : DELTA_W) + 1;
    localparam logic signed [SUM_W-1:0] LIM_HI  = SUM_W'(COUNT_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_LO  = SUM_W'(-COUNT_LIMIT);
    localparam logic signed [CNT_W-1:0] SNAP_HI = CNT_W'(SNAP_MAX);
    localparam logic signed [CNT_W-1:0] SNAP_LO = CNT_W'(-SNAP_MAX - 1);

    // input register
    logic                      in_valid_reg;
    logic [2:0]                opcode_reg;
    logic [1:0]                sel_reg;
    logic [7:0]                data_reg;
    logic                      is_y_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic                      is_right_reg;
    logic                      down_reg;

    // block state
    logic [7:0]              port_a_reg;
    logic [7:0]              port_b_reg;
    logic [7:0]              port_c_reg;
    logic [7:0]              mode_reg;
    logic signed [CNT_W-1:0] count_x_reg;
    logic signed [CNT_W-1:0] count_y_reg;
    logic signed [7:0]       snap_x_reg;
    logic signed [7:0]       snap_y_reg;
    logic                    left_up_reg;
    logic                    right_up_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] read_data_reg;
    logic       irq_pulse_reg;

    logic [7:0]              port_a_next;
    logic [7:0]              port_b_next;
    logic [7:0]              port_c_next;
    logic [7:0]              mode_next;
    logic signed [CNT_W-1:0] count_x_next;
    logic signed [CNT_W-1:0] count_y_next;
    logic signed [7:0]       snap_x_next;
    logic signed [7:0]       snap_y_next;
    logic                    left_up_next;
    logic                    right_up_next;
    logic [7:0]              read_data_next;
    logic                    irq_pulse_next;

    logic                    accept;
    logic                    advance;
    logic                    c_write;
    logic [7:0]              c_value;
    logic [7:0]              c_bitmask;
    logic signed [SUM_W-1:0] motion_sum;
    logic signed [CNT_W-1:0] motion_sat;
    logic signed [CNT_W-1:0] snap_x_wide;
    logic signed [CNT_W-1:0] snap_y_wide;
    logic [7:0]              nibble_src;
    logic [7:0]              port_a_read;
    logic [7:0]              port_c_read;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg   <= opcode;
            sel_reg      <= port_select;
            data_reg     <= write_data;
            is_y_reg     <= axis_is_y;
            delta_reg    <= motion_delta;
            is_right_reg <= button_is_right;
            down_reg     <= button_down;
        end
    end

    // saturating motion update on the selected axis
    always_comb
    begin
        motion_sum = (is_y_reg ? SUM_W'(count_y_reg) : SUM_W'(count_x_reg))
                   + SUM_W'(delta_reg);
        if (motion_sum > LIM_HI)
        begin
            motion_sat = CNT_W'(LIM_HI);
        end
        else if (motion_sum < LIM_LO)
        begin
            motion_sat = CNT_W'(LIM_LO);
        end
        else
        begin
            motion_sat = CNT_W'(motion_sum);
        end
    end

    // latch values, clamped to a signed byte
    always_comb
    begin
        snap_x_wide = (count_x_reg > SNAP_HI) ? SNAP_HI :
                      (count_x_reg < SNAP_LO) ? SNAP_LO : count_x_reg;
        snap_y_wide = (count_y_reg > SNAP_HI) ? SNAP_HI :
                      (count_y_reg < SNAP_LO) ? SNAP_LO : count_y_reg;
    end

    // read paths
    always_comb
    begin
        if (port_c_reg[7])
        begin
            nibble_src = port_c_reg[6] ? snap_y_reg : snap_x_reg;
        end
        else
        begin
            nibble_src = port_c_reg[6] ? count_y_reg[7:0] : count_x_reg[7:0];
        end
        port_a_read = {left_up_reg, 1'b1, right_up_reg, 1'b0,
                       port_c_reg[5] ? nibble_src[7:4] : nibble_src[3:0]};

        port_c_read = port_c_reg;
        if (mode_reg[3])
        begin
            port_c_read = port_c_read & PORT_C_MASK;
        end
        if (mode_reg[0])
        begin
            port_c_read = {port_c_read[7:4], PORT_C_STRAP};
        end
    end

    always_comb
    begin
        port_a_next    = port_a_reg;
        port_b_next    = port_b_reg;
        mode_next      = mode_reg;
        count_x_next   = count_x_reg;
        count_y_next   = count_y_reg;
        snap_x_next    = snap_x_reg;
        snap_y_next    = snap_y_reg;
        left_up_next   = left_up_reg;
        right_up_next  = right_up_reg;
        read_data_next = '0;
        irq_pulse_next = 1'b0;
        c_write        = 1'b0;
        c_value        = port_c_reg;
        c_bitmask      = 8'b1 << data_reg[3:1];

        case (opcode_reg)
            OP_READ:
            begin
                case (sel_reg)
                    SEL_PORT_A:
                        read_data_next = mode_reg[4] ? port_a_read : port_a_reg;
                    SEL_PORT_B:
                        read_data_next = mode_reg[1] ? PORT_B_STRAP : port_b_reg;
                    SEL_PORT_C:
                        read_data_next = port_c_read;
                    default:
                        read_data_next = CONTROL_READ;
                endcase
            end
            OP_WRITE:
            begin
                case (sel_reg)
                    SEL_PORT_A:
                        port_a_next = data_reg;
                    SEL_PORT_B:
                        port_b_next = data_reg;
                    SEL_PORT_C:
                    begin
                        c_write = 1'b1;
                        c_value = data_reg;
                    end
                    default:
                    begin
                        c_write = 1'b1;
                        if (data_reg[7])
                        begin
                            // mode word: also clears port C
                            mode_next = data_reg;
                            c_value   = '0;
                        end
                        else if (data_reg[0])
                        begin
                            c_value = port_c_reg | c_bitmask;
                        end
                        else
                        begin
                            c_value = port_c_reg & ~c_bitmask;
                        end
                    end
                endcase
            end
            OP_MOTION:
            begin
                if (is_y_reg)
                begin
                    count_y_next = motion_sat;
                end
                else
                begin
                    count_x_next = motion_sat;
                end
            end
            OP_BUTTON:
            begin
                if (is_right_reg)
                begin
                    right_up_next = !down_reg;
                end
                else
                begin
                    left_up_next = !down_reg;
                end
            end
            OP_TICK:
                irq_pulse_next = !port_c_reg[4];
            default:
            begin
            end
        endcase

        port_c_next = c_write ? c_value : port_c_reg;

        // rising edge of the latch bit: snapshot and clear both counters
        if (c_write && c_value[7] && !port_c_reg[7])
        begin
            snap_x_next  = 8'(snap_x_wide);
            snap_y_next  = 8'(snap_y_wide);
            count_x_next = '0;
            count_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg    <= '0;
            port_b_reg    <= '0;
            port_c_reg    <= PORT_C_RESET;
            mode_reg      <= MODE_RESET;
            count_x_reg   <= '0;
            count_y_reg   <= '0;
            snap_x_reg    <= '1;
            snap_y_reg    <= '1;
            left_up_reg   <= 1'b1;
            right_up_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            read_data_reg <= '0;
            irq_pulse_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                port_a_reg    <= port_a_next;
                port_b_reg    <= port_b_next;
                port_c_reg    <= port_c_next;
                mode_reg      <= mode_next;
                count_x_reg   <= count_x_next;
                count_y_reg   <= count_y_next;
                snap_x_reg    <= snap_x_next;
                snap_y_reg    <= snap_y_next;
                left_up_reg   <= left_up_next;
                right_up_reg  <= right_up_next;
                read_data_reg <= read_data_next;
                irq_pulse_reg <= irq_pulse_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_pulse = irq_pulse_reg;

    a_count_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_x_reg <= CNT_W'(COUNT_LIMIT)) && (count_x_reg >= CNT_W'(-COUNT_LIMIT)))
        else $error("X counter outside saturation range");

    a_count_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_y_reg <= CNT_W'(COUNT_LIMIT)) && (count_y_reg >= CNT_W'(-COUNT_LIMIT)))
        else $error("Y counter outside saturation range");

    a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_pulse |-> read_data == '0)
        else $error("interrupt pulse carries read data");

    a_latch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (opcode_reg == OP_WRITE) && (sel_reg == SEL_PORT_C)
            && data_reg[7] && !port_c_reg[7]
        |=> (count_x_reg == '0) && (count_y_reg == '0) && port_c_reg[7])
        else $error("latch edge did not clear the counters");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg && $stable(opcode_reg) && $stable(delta_reg))
        else $error("held transaction lost from input register");

endmodule

### tb/bus_mouse_ppi_interface_tb.sv
`timescale 1ns / 1ps

module bus_mouse_ppi_interface_tb;
    import bmpi_pkg::*;

    localparam int COUNT_LIM    = DEF_COUNT_LIMIT;
    localparam int RANDOM_ITEMS = 1250;
    localparam int OP_MAX       = 7;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTS   = 20;

    // port C bit positions
    localparam int PC_LATCH_BIT   = 7;
    localparam int PC_SEL_Y_BIT   = 6;
    localparam int PC_HI_NIB_BIT  = 5;
    localparam int PC_IRQ_OFF_BIT = 4;

    // mode word bit positions
    localparam int MODE_WORD_BIT     = 7;
    localparam int MODE_MOUSE_BIT    = 4;
    localparam int MODE_PC_MASK_BIT  = 3;
    localparam int MODE_PB_STRAP_BIT = 1;
    localparam int MODE_PC_STRAP_BIT = 0;

    localparam logic [7:0] MODE_FLAG   = 8'h80;
    localparam logic [7:0] BTN_LEFT    = 8'h80;
    localparam logic [7:0] BTN_RIGHT   = 8'h20;
    localparam logic [7:0] BTN_RELEASE = 8'ha0;

    typedef struct {
        logic [2:0]                 op;
        logic [1:0]                 sel;
        logic [7:0]                 wdata;
        logic                       is_y;
        logic signed [DELTA_W-1:0]  delta;
        logic                       is_right;
        logic                       down;
    } mouse_txn_t;

    typedef struct {
        logic [7:0] rd;
        logic       irq;
    } mouse_res_t;

    logic                       clk;
    logic                       rst_n           = 1'b0;
    logic                       in_valid        = 1'b0;
    logic                       in_stall;
    logic [2:0]                 opcode          = '0;
    logic [1:0]                 port_select     = '0;
    logic [7:0]                 write_data      = '0;
    logic                       axis_is_y       = 1'b0;
    logic signed [DELTA_W-1:0]  motion_delta    = '0;
    logic                       button_is_right = 1'b0;
    logic                       button_down     = 1'b0;
    logic                       out_valid;
    logic                       out_stall       = 1'b0;
    logic [7:0]                 read_data;
    logic                       irq_pulse;

    bus_mouse_ppi_interface #(
        .COUNT_LIMIT(COUNT_LIM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .port_select(port_select),
        .write_data(write_data),
        .axis_is_y(axis_is_y),
        .motion_delta(motion_delta),
        .button_is_right(button_is_right),
        .button_down(button_down),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .irq_pulse(irq_pulse)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    mouse_txn_t pending_txns[$];
    mouse_res_t expected_results[$];

    int err_count   = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_reads     = 0;
    int n_irqs      = 0;
    int n_snapshots = 0;

    // mirror of the mouse interface state
    logic [7:0] port_a;
    logic [7:0] port_b;
    logic [7:0] port_c;
    logic [7:0] mode;
    logic [7:0] buttons;
    int         cnt_x;
    int         cnt_y;
    int         snap_x;
    int         snap_y;

    function automatic void clear_mouse_state();
        port_a  = '0;
        port_b  = '0;
        port_c  = PORT_C_RESET;
        mode    = MODE_RESET;
        buttons = BTN_RELEASE;
        cnt_x   = 0;
        cnt_y   = 0;
        snap_x  = -1;
        snap_y  = -1;
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void store_port_c(logic [7:0] v);
        // latch bit rising: snapshot both counters and clear them
        if (v[PC_LATCH_BIT] && !port_c[PC_LATCH_BIT])
        begin
            snap_x = clamp_int(cnt_x, -SNAP_MAX - 1, SNAP_MAX);
            snap_y = clamp_int(cnt_y, -SNAP_MAX - 1, SNAP_MAX);
            cnt_x  = 0;
            cnt_y  = 0;
            n_snapshots++;
        end
        port_c = v;
    endfunction

    function automatic logic [7:0] bus_read(logic [1:0] sel);
        logic [7:0]  r;
        int          val;
        logic [31:0] bits;
        case (sel)
            SEL_PORT_A:
            begin
                if (!mode[MODE_MOUSE_BIT])
                    r = port_a;
                else
                begin
                    r = (buttons & 8'hf0) | PORT_A_SIG;
                    if (port_c[PC_LATCH_BIT])
                        val = port_c[PC_SEL_Y_BIT] ? snap_y : snap_x;
                    else
                        val = port_c[PC_SEL_Y_BIT] ? cnt_y : cnt_x;
                    bits = val;
                    r[3:0] = port_c[PC_HI_NIB_BIT] ? bits[7:4] : bits[3:0];
                end
            end
            SEL_PORT_B:
                r = mode[MODE_PB_STRAP_BIT] ? PORT_B_STRAP : port_b;
            SEL_PORT_C:
            begin
                r = port_c;
                if (mode[MODE_PC_MASK_BIT])
                    r = r & PORT_C_MASK;
                if (mode[MODE_PC_STRAP_BIT])
                    r[3:0] = PORT_C_STRAP;
            end
            default:
                r = CONTROL_READ;
        endcase
        return r;
    endfunction

    function automatic void bus_write(logic [1:0] sel, logic [7:0] v);
        logic [7:0] c;
        case (sel)
            SEL_PORT_A: port_a = v;
            SEL_PORT_B: port_b = v;
            SEL_PORT_C: store_port_c(v);
            default:
            begin
                if (v[MODE_WORD_BIT])
                begin
                    mode = v;
                    store_port_c(8'h00);
                end
                else
                begin
                    c = port_c;
                    c[v[3:1]] = v[0];
                    store_port_c(c);
                end
            end
        endcase
    endfunction

    function automatic mouse_res_t predict_mouse(mouse_txn_t t);
        mouse_res_t res;
        logic [7:0] mask;
        res.rd  = '0;
        res.irq = 1'b0;
        case (t.op)
            OP_READ:
            begin
                res.rd = bus_read(t.sel);
                n_reads++;
            end
            OP_WRITE:
                bus_write(t.sel, t.wdata);
            OP_MOTION:
            begin
                if (t.is_y)
                    cnt_y = clamp_int(cnt_y + int'(t.delta), -COUNT_LIM, COUNT_LIM);
                else
                    cnt_x = clamp_int(cnt_x + int'(t.delta), -COUNT_LIM, COUNT_LIM);
            end
            OP_BUTTON:
            begin
                mask = t.is_right ? BTN_RIGHT : BTN_LEFT;
                buttons = t.down ? (buttons & ~mask) : (buttons | mask);
            end
            OP_TICK:
            begin
                if (!port_c[PC_IRQ_OFF_BIT])
                begin
                    res.irq = 1'b1;
                    n_irqs++;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        if (err_count < MAX_PRINTS)
            $display("%0t: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // stimulus helpers: fields the operation ignores carry random noise
    function automatic mouse_txn_t noise_txn();
        mouse_txn_t t;
        t.op       = 3'($urandom_range(0, OP_MAX));
        t.sel      = 2'($urandom_range(0, 3));
        t.wdata    = 8'($urandom_range(0, 255));
        t.is_y     = 1'($urandom_range(0, 1));
        t.delta    = DELTA_W'($urandom_range(0, (1 << DELTA_W) - 1));
        t.is_right = 1'($urandom_range(0, 1));
        t.down     = 1'($urandom_range(0, 1));
        return t;
    endfunction

    task automatic push_bus(logic [2:0] op, logic [1:0] sel, logic [7:0] data);
        mouse_txn_t t;
        t = noise_txn();
        t.op    = op;
        t.sel   = sel;
        t.wdata = data;
        pending_txns.push_back(t);
    endtask

    task automatic push_motion(logic is_y, int delta);
        mouse_txn_t t;
        t = noise_txn();
        t.op    = OP_MOTION;
        t.is_y  = is_y;
        t.delta = DELTA_W'(delta);
        pending_txns.push_back(t);
    endtask

    task automatic push_button(logic is_right, logic down);
        mouse_txn_t t;
        t = noise_txn();
        t.op       = OP_BUTTON;
        t.is_right = is_right;
        t.down     = down;
        pending_txns.push_back(t);
    endtask

    // control word that sets or clears a single port C bit
    function automatic logic [7:0] ctrl_bit(int idx, logic v);
        return {4'b0000, 3'(idx), v};
    endfunction

    function automatic int rand_delta();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, (1 << DELTA_W) - 1) - (1 << (DELTA_W - 1));
        return $urandom_range(0, 400) - 200;
    endfunction

    // sender: bursts of random length separated by random gaps
    mouse_txn_t on_bus;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_mouse(on_bus));
                n_accepted++;
            end
            // hold the payload while the transaction is stalled
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_txns.size() > 0)
                begin
                    on_bus = pending_txns.pop_front();
                    opcode          <= on_bus.op;
                    port_select     <= on_bus.sel;
                    write_data      <= on_bus.wdata;
                    axis_is_y       <= on_bus.is_y;
                    motion_delta    <= on_bus.delta;
                    button_is_right <= on_bus.is_right;
                    button_down     <= on_bus.down;
                    in_valid        <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: check results and stall on one of four patterns, re-picked at random
    int         stall_cycle = 0;
    int         stall_mode  = 0;
    mouse_res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_results.size() == 0)
                    flag_mismatch("result with no transaction outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.rd)
                        flag_mismatch($sformatf("read_data %02h, expected %02h",
                                                read_data, want.rd));
                    if (irq_pulse !== want.irq)
                        flag_mismatch($sformatf("irq_pulse %b, expected %b",
                                                irq_pulse, want.irq));
                end
            end
            stall_cycle++;
            if (stall_cycle % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= (stall_cycle % 5 < 2);
                default: out_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d transactions still expected", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int total;
        int pick;
        int n;
        clear_mouse_state();

        // directed: port reads at reset, saturation, buttons, snapshot, modes
        push_bus(OP_READ, SEL_PORT_A, 8'h00);
        push_bus(OP_READ, SEL_PORT_B, 8'h00);
        push_bus(OP_READ, SEL_PORT_C, 8'h00);
        push_bus(OP_READ, SEL_CONTROL, 8'h00);
        push_bus(OP_TICK, SEL_PORT_A, 8'h00);
        push_motion(1'b0, (1 << (DELTA_W - 1)) - 1);
        push_motion(1'b1, -(1 << (DELTA_W - 1)));
        push_motion(1'b1, -(1 << (DELTA_W - 1)));
        push_button(1'b0, 1'b1);
        push_button(1'b1, 1'b1);
        push_button(1'b0, 1'b0);
        push_bus(OP_READ, SEL_PORT_A, 8'h00);
        push_bus(OP_WRITE, SEL_CONTROL, ctrl_bit(PC_LATCH_BIT, 1'b0));
        push_bus(OP_WRITE, SEL_CONTROL, ctrl_bit(PC_LATCH_BIT, 1'b1));
        push_bus(OP_WRITE, SEL_PORT_C, 8'he0);
        push_bus(OP_READ, SEL_PORT_A, 8'h00);
        push_bus(OP_WRITE, SEL_CONTROL, ctrl_bit(PC_SEL_Y_BIT, 1'b0));
        push_bus(OP_WRITE, SEL_CONTROL, ctrl_bit(PC_HI_NIB_BIT, 1'b0));
        push_bus(OP_READ, SEL_PORT_A, 8'h00);
        push_bus(OP_WRITE, SEL_CONTROL, MODE_FLAG);
        push_bus(OP_TICK, SEL_PORT_A, 8'h00);
        push_bus(OP_WRITE, SEL_PORT_A, 8'ha5);
        push_bus(OP_READ, SEL_PORT_A, 8'h00);
        push_bus(OP_WRITE, SEL_PORT_B, 8'h5a);
        push_bus(OP_READ, SEL_PORT_B, 8'h00);
        push_bus(OP_WRITE, SEL_CONTROL, 8'h89);
        push_bus(OP_WRITE, SEL_PORT_C, 8'hff);
        push_bus(OP_READ, SEL_PORT_C, 8'h00);
        for (int k = int'(OP_TICK) + 1; k <= OP_MAX; k++)
            push_bus(3'(k), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));

        total = pending_txns.size() + RANDOM_ITEMS;
        while (pending_txns.size() < total)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                push_motion(1'($urandom_range(0, 1)), rand_delta());
            else if (pick < 23)
                push_button(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (pick < 33)
            begin
                // set or clear the interrupt disable bit at random, then tick
                push_bus(OP_WRITE, SEL_CONTROL,
                         ctrl_bit(PC_IRQ_OFF_BIT, 1'($urandom_range(0, 1))));
                n = $urandom_range(1, 3);
                repeat (n) push_bus(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else if (pick < 45)
                push_bus(OP_READ, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else if (pick < 53)
                push_bus(OP_WRITE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else if (pick < 60)
                push_bus(OP_WRITE, SEL_CONTROL,
                         ($urandom_range(0, 1) == 1) ? (MODE_FLAG | 8'($urandom_range(0, 127)))
                                                     : 8'($urandom_range(0, 127)));
            else if (pick < 90)
            begin
                // typical poll: optional mode word, motion, latch, read port A nibbles picked at random
                if ($urandom_range(0, 1) == 1)
                    push_bus(OP_WRITE, SEL_CONTROL,
                             MODE_FLAG | 8'h10 | 8'($urandom_range(0, 15)));
                n = $urandom_range(0, 4);
                repeat (n) push_motion(1'($urandom_range(0, 1)), rand_delta());
                push_bus(OP_WRITE, SEL_CONTROL, ctrl_bit(PC_LATCH_BIT, 1'b0));
                if ($urandom_range(0, 3) == 0)
                    push_bus(OP_READ, SEL_PORT_A, 8'($urandom_range(0, 255)));
                push_bus(OP_WRITE, SEL_CONTROL, ctrl_bit(PC_LATCH_BIT, 1'b1));
                n = $urandom_range(2, 4);
                repeat (n)
                begin
                    push_bus(OP_WRITE, SEL_CONTROL,
                             ctrl_bit(PC_SEL_Y_BIT, 1'($urandom_range(0, 1))));
                    push_bus(OP_WRITE, SEL_CONTROL,
                             ctrl_bit(PC_HI_NIB_BIT, 1'($urandom_range(0, 1))));
                    push_bus(OP_READ, SEL_PORT_A, 8'($urandom_range(0, 255)));
                end
            end
            else
                pending_txns.push_back(noise_txn());
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_txns.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions, checked %0d results.", n_accepted, n_results);
        $display("Covered %0d bus reads, %0d interrupt pulses and %0d counter snapshots.",
                 n_reads, n_irqs, n_snapshots);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
src/bmpi_pkg.sv
src/bus_mouse_ppi_interface.sv
tb/bus_mouse_ppi_interface_tb.sv
